// ----- rtl/core/rm2aa_pkg.sv -----
// ----------------------------------------------------------------------------
// rm2aa_pkg
// shared widths, constants, types and the arctangent table of the
// rotation matrix to axis angle datapath
// ----------------------------------------------------------------------------
package rm2aa_pkg;

    localparam int MAT_W        = 16;
    localparam int IN_W         = 9 * MAT_W;
    localparam int D_W          = 17;
    localparam int MAG_W        = 16;
    localparam int SQ_W         = 32;
    localparam int ROT_W        = 17;
    localparam int OUT_W        = 56;
    localparam int USER_W       = 3;
    localparam int SQRT_QW      = 32;
    localparam int RAD_W        = 2 * SQRT_QW;
    localparam int XY_W         = 36;
    localparam int ANG_W        = 25;
    localparam int ANGU_W       = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int L_W          = 32;
    localparam int PROD_W       = MAG_W + ANGU_W;
    localparam int DEN_W        = L_W + 1;
    localparam int QUOT_W       = 17;
    localparam int CMP_W        = DEN_W + QUOT_W - 1;

    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 25'sd5898226;
    localparam logic [ANGU_W-1:0]       ANG_MAX      = 24'd11796452;
    localparam logic signed [ROT_W-1:0] ROT_LIM      = 17'sd46081;

    typedef enum logic [1:0] {
        AXIS_Z = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_X = 2'd2
    } axis_t;

    // per item side information carried beside the angle path
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
        axis_t                 axis;
        logic                  degen;
    } side_t;

    typedef struct packed {
        logic [L_W-1:0] len;
        side_t          info;
    } cside_t;

    typedef struct packed {
        logic [2:0] neg;
        axis_t      axis;
        logic       degen;
    } flags_t;

    // arctangent of 2^-idx in degree units with 16 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            0:       val = 25'sd2949113;
            1:       val = 25'sd1740963;
            2:       val = 25'sd919877;
            3:       val = 25'sd466944;
            4:       val = 25'sd234378;
            5:       val = 25'sd117303;
            6:       val = 25'sd58666;
            7:       val = 25'sd29335;
            8:       val = 25'sd14668;
            9:       val = 25'sd7334;
            10:      val = 25'sd3667;
            11:      val = 25'sd1833;
            12:      val = 25'sd917;
            13:      val = 25'sd458;
            14:      val = 25'sd229;
            15:      val = 25'sd115;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/core/rm2aa_isqrt.sv -----
// ----------------------------------------------------------------------------
// rm2aa_isqrt
// pipelined floor square root, one result bit per stage, with a tag beside it
// ----------------------------------------------------------------------------
module rm2aa_isqrt
    import rm2aa_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [RAD_W-1:0]   in_rad,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_valid,
    output logic [SQRT_QW-1:0] out_root,
    output logic [TAG_W-1:0]   out_tag
);

    localparam int REM_W = SQRT_QW + 3;

    logic                vld_reg  [SQRT_QW];
    logic [REM_W-1:0]    rem_reg  [SQRT_QW];
    logic [SQRT_QW-1:0]  root_reg [SQRT_QW];
    logic [RAD_W-1:0]    rad_reg  [SQRT_QW];
    logic [TAG_W-1:0]    tag_reg  [SQRT_QW];

    for (genvar k = 0; k < SQRT_QW; k++)
    begin : g_stage
        logic               v_in;
        logic [REM_W-1:0]   rem_in;
        logic [SQRT_QW-1:0] root_in;
        logic [RAD_W-1:0]   rad_in;
        logic [TAG_W-1:0]   tag_in;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;
        logic [REM_W-1:0]   rem_next;
        logic [SQRT_QW-1:0] root_next;

        if (k == 0)
        begin : g_head
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign tag_in  = in_tag;
        end
        else
        begin : g_body
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign tag_in  = tag_reg[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        always_comb
        begin
            rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial  = {{(REM_W-SQRT_QW-2){1'b0}}, root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[SQRT_QW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[SQRT_QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_QW-1];
    assign out_root  = root_reg[SQRT_QW-1];
    assign out_tag   = tag_reg[SQRT_QW-1];

endmodule

// ----- rtl/core/rm2aa_div3.sv -----
// ----------------------------------------------------------------------------
// rm2aa_div3
// scales three magnitudes by the angle and divides each by the axis length,
// rounding half up, one quotient bit per stage
// ----------------------------------------------------------------------------
module rm2aa_div3
    import rm2aa_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ANGU_W-1:0]       in_ang,
    input  logic [L_W-1:0]          in_len,
    input  logic [2:0][MAG_W-1:0]   in_mag,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic [2:0][QUOT_W-1:0]  out_quot,
    output logic [TAG_W-1:0]        out_tag
);

    // stage a: products
    logic              a_valid_reg;
    logic [PROD_W-1:0] a_prod_reg [3];
    logic [L_W-1:0]    a_len_reg;
    logic [TAG_W-1:0]  a_tag_reg;

    // stage b: numerator mag*ang*128 + len, denominator 2*len
    logic              b_valid_reg;
    logic [CMP_W-1:0]  b_num_reg [3];
    logic [DEN_W-1:0]  b_den_reg;
    logic [TAG_W-1:0]  b_tag_reg;

    logic              q_valid_reg [QUOT_W];
    logic [CMP_W-1:0]  q_num_reg   [QUOT_W][3];
    logic [QUOT_W-1:0] q_quot_reg  [QUOT_W][3];
    logic [DEN_W-1:0]  q_den_reg   [QUOT_W];
    logic [TAG_W-1:0]  q_tag_reg   [QUOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_prod_reg[i] <= PROD_W'(in_mag[i]) * PROD_W'(in_ang);
                b_num_reg[i]  <= CMP_W'({a_prod_reg[i], 7'b0}) + CMP_W'(a_len_reg);
            end
            a_len_reg <= in_len;
            a_tag_reg <= in_tag;
            b_den_reg <= {a_len_reg, 1'b0};
            b_tag_reg <= a_tag_reg;
        end
    end

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_stage
        localparam int BIT = QUOT_W - 1 - k;

        logic              v_in;
        logic [CMP_W-1:0]  num_in  [3];
        logic [QUOT_W-1:0] quot_in [3];
        logic [DEN_W-1:0]  den_in;
        logic [TAG_W-1:0]  tag_in;
        logic [CMP_W-1:0]  dsh;
        logic [CMP_W-1:0]  num_next  [3];
        logic [QUOT_W-1:0] quot_next [3];

        if (k == 0)
        begin : g_head
            assign v_in   = b_valid_reg;
            assign den_in = b_den_reg;
            assign tag_in = b_tag_reg;
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign num_in[i]  = b_num_reg[i];
                assign quot_in[i] = '0;
            end
        end
        else
        begin : g_body
            assign v_in   = q_valid_reg[k-1];
            assign den_in = q_den_reg[k-1];
            assign tag_in = q_tag_reg[k-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign num_in[i]  = q_num_reg[k-1][i];
                assign quot_in[i] = q_quot_reg[k-1][i];
            end
        end

        always_comb
        begin
            dsh = CMP_W'(den_in) << BIT;
            for (int i = 0; i < 3; i++)
            begin
                if (num_in[i] >= dsh)
                begin
                    num_next[i]       = num_in[i] - dsh;
                    quot_next[i]      = quot_in[i];
                    quot_next[i][BIT] = 1'b1;
                end
                else
                begin
                    num_next[i]  = num_in[i];
                    quot_next[i] = quot_in[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                q_valid_reg[k] <= 1'b0;
            else if (en)
                q_valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q_num_reg[k][i]  <= num_next[i];
                    q_quot_reg[k][i] <= quot_next[i];
                end
                q_den_reg[k] <= den_in;
                q_tag_reg[k] <= tag_in;
            end
        end
    end

    assign out_valid = q_valid_reg[QUOT_W-1];
    assign out_tag   = q_tag_reg[QUOT_W-1];
    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign out_quot[i] = q_quot_reg[QUOT_W-1][i];
    end

endmodule

// ----- rtl/core/rotation_matrix_to_axis_angle.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_axis_angle
// rotation vector in degrees (Q8.8) and dominant axis of a 3x3 rotation matrix
// ----------------------------------------------------------------------------
// pipeline: 3 front stages, 32 square root stages, 18 cordic and clamp
//   stages, 19 scale and divide stages, 1 output register
// throughput: one item per cycle while the output is not stalled, set by
//   the fully pipelined datapath
// a stalled output freezes every stage; one extra item is caught in the input
//   skid register
// reset: asynchronous active low, clears all valid bits; no other state
module rotation_matrix_to_axis_angle
    import rm2aa_pkg::*;
#(
    parameter int ENTRY_FRAC_BITS = 14
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // rot_x[16:0], rot_y[33:17], rot_z[50:34], zero pad
    output logic [OUT_W-1:0]  m_axis_tdata,
    // dominant_axis[1:0], degenerate[2]
    output logic [USER_W-1:0] m_axis_tuser
);

    localparam int F   = ENTRY_FRAC_BITS;
    localparam int TW  = F + 3;                        // saturated twice-cosine
    localparam int SW  = ((F + 2 > 18) ? F + 2 : 18) + 1; // raw trace sum
    localparam int RSW = 2 * F + 3;                    // sine radicand
    localparam int SH  = 32 - F;                       // scale to cordic range

    localparam logic signed [SW-1:0] ONE_S = {{(SW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [SW-1:0] T_HI  = {{(SW-F-2){1'b0}}, 1'b1, {(F+1){1'b0}}};
    localparam logic signed [SW-1:0] T_LO  = -T_HI;
    localparam logic [RSW-1:0]       RS_TOP = {1'b1, {(2*F+2){1'b0}}};

    // ------------------------------------------------------------------
    // global advance and input skid register
    // ------------------------------------------------------------------
    logic                    en;
    logic                    skid_valid_reg;
    logic [IN_W-1:0]         skid_data_reg;
    logic                    in_take;
    logic                    in_vld;
    logic [IN_W-1:0]         in_data;
    logic                    out_valid_reg;

    // pipeline moves whenever the output register is free or being drained
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign in_vld        = skid_valid_reg || in_take;
    assign in_data       = skid_valid_reg ? skid_data_reg : s_axis_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else if (en)
            skid_valid_reg <= 1'b0;
        else if (in_take)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!en && in_take)
            skid_data_reg <= s_axis_tdata;
    end

    // ------------------------------------------------------------------
    // stage 1: difference vector and saturated trace
    // ------------------------------------------------------------------
    logic signed [MAT_W-1:0] m [9];
    logic signed [SW-1:0]    tsum;
    logic signed [TW-1:0]    t_next;
    logic signed [D_W-1:0]   d_next [3];

    logic                    p1_valid_reg;
    logic signed [D_W-1:0]   p1_d_reg [3];
    logic signed [TW-1:0]    p1_t_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            m[i] = $signed(in_data[i*MAT_W +: MAT_W]);
        d_next[0] = D_W'(m[7]) - D_W'(m[5]);   // m21 - m12
        d_next[1] = D_W'(m[2]) - D_W'(m[6]);   // m02 - m20
        d_next[2] = D_W'(m[3]) - D_W'(m[1]);   // m10 - m01
        tsum = SW'(m[0]) + SW'(m[4]) + SW'(m[8]) - ONE_S;
        if (tsum > T_HI)
            t_next = TW'(T_HI);
        else if (tsum < T_LO)
            t_next = TW'(T_LO);
        else
            t_next = TW'(tsum);
    end

    // ------------------------------------------------------------------
    // stage 2: squares, magnitudes, dominant axis, degenerate check
    // ------------------------------------------------------------------
    logic signed [2*TW-1:0]  tt_full;
    logic signed [2*D_W-1:0] sq_full [3];
    logic signed [D_W-1:0]   dabs [3];
    side_t                   side_next;

    logic                    p2_valid_reg;
    logic [SQ_W-1:0]         p2_sq_reg [3];
    logic [RSW-1:0]          p2_tt_reg;
    logic signed [TW-1:0]    p2_t_reg;
    side_t                   p2_side_reg;

    always_comb
    begin
        tt_full = p1_t_reg * p1_t_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq_full[i]        = p1_d_reg[i] * p1_d_reg[i];
            dabs[i]           = p1_d_reg[i][D_W-1] ? -p1_d_reg[i] : p1_d_reg[i];
            side_next.neg[i]  = p1_d_reg[i][D_W-1];
            side_next.mag[i]  = dabs[i][MAG_W-1:0];
        end
        // ties go to z, then y
        if (side_next.mag[2] >= side_next.mag[1] && side_next.mag[2] >= side_next.mag[0])
            side_next.axis = AXIS_Z;
        else if (side_next.mag[1] >= side_next.mag[0])
            side_next.axis = AXIS_Y;
        else
            side_next.axis = AXIS_X;
        side_next.degen = (p1_d_reg[0] == '0) && (p1_d_reg[1] == '0) && (p1_d_reg[2] == '0);
    end

    // ------------------------------------------------------------------
    // stage 3: radicands for twice-sine and axis length
    // ------------------------------------------------------------------
    logic [SQ_W+1:0]         sqsum;

    logic                    p3_valid_reg;
    logic [RAD_W-1:0]        p3_rads_reg;
    logic [RAD_W-1:0]        p3_radl_reg;
    logic signed [TW-1:0]    p3_t_reg;
    side_t                   p3_side_reg;

    assign sqsum = (SQ_W+2)'(p2_sq_reg[0]) + (SQ_W+2)'(p2_sq_reg[1]) +
                   (SQ_W+2)'(p2_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_vld;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_d_reg[i]  <= d_next[i];
                p2_sq_reg[i] <= sq_full[i][SQ_W-1:0];
            end
            p1_t_reg    <= t_next;
            p2_tt_reg   <= tt_full[RSW-1:0];
            p2_t_reg    <= p1_t_reg;
            p2_side_reg <= side_next;
            p3_rads_reg <= {{(RAD_W-RSW){1'b0}}, RS_TOP - p2_tt_reg};
            p3_radl_reg <= {2'b00, sqsum, 28'b0};
            p3_t_reg    <= p2_t_reg;
            p3_side_reg <= p2_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // square roots: twice-sine and scaled axis length, in lockstep
    // ------------------------------------------------------------------
    logic                    sa_valid;
    logic [SQRT_QW-1:0]      s_root;
    logic [TW-1:0]           sa_t;
    logic                    sb_valid;
    logic [SQRT_QW-1:0]      l_root;
    side_t                   sb_side;

    rm2aa_isqrt #(
        .TAG_W (TW)
    ) u_sqrt_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p3_valid_reg),
        .in_rad    (p3_rads_reg),
        .in_tag    (p3_t_reg),
        .out_valid (sa_valid),
        .out_root  (s_root),
        .out_tag   (sa_t)
    );

    rm2aa_isqrt #(
        .TAG_W ($bits(side_t))
    ) u_sqrt_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p3_valid_reg),
        .in_rad    (p3_radl_reg),
        .in_tag    (p3_side_reg),
        .out_valid (sb_valid),
        .out_root  (l_root),
        .out_tag   (sb_side)
    );

    // ------------------------------------------------------------------
    // cordic vectoring: angle of (twice-cosine, twice-sine)
    // index 0 is the pre-rotated start vector, index k is after step k-1
    // ------------------------------------------------------------------
    logic                    cv_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]  cx_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]  cy_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] ca_reg [CORDIC_STEPS+1];
    cside_t                  cs_reg [CORDIC_STEPS+1];

    logic signed [XY_W-1:0]  x_ini;
    logic signed [XY_W-1:0]  y_ini;
    logic signed [XY_W-1:0]  x0_next;
    logic signed [XY_W-1:0]  y0_next;
    logic signed [ANG_W-1:0] a0_next;

    always_comb
    begin
        x_ini = XY_W'($signed(sa_t)) <<< SH;
        y_ini = $signed(XY_W'(s_root) << SH);
        // left half plane: turn by -90 degrees first
        if (x_ini < 0)
        begin
            x0_next = y_ini;
            y0_next = -x_ini;
            a0_next = QUARTER_TURN;
        end
        else
        begin
            x0_next = x_ini;
            y0_next = y_ini;
            a0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (en)
            cv_reg[0] <= sa_valid && sb_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= x0_next;
            cy_reg[0] <= y0_next;
            ca_reg[0] <= a0_next;
            cs_reg[0] <= '{len: l_root, info: sb_side};
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS; k++)
    begin : g_cordic
        localparam int SHIFT = k - 1;

        logic signed [XY_W-1:0]  xs;
        logic signed [XY_W-1:0]  ys;
        logic signed [XY_W-1:0]  x_next;
        logic signed [XY_W-1:0]  y_next;
        logic signed [ANG_W-1:0] a_next;

        always_comb
        begin
            xs = cx_reg[k-1] >>> SHIFT;
            ys = cy_reg[k-1] >>> SHIFT;
            if (cy_reg[k-1] > 0)
            begin
                x_next = cx_reg[k-1] + ys;
                y_next = cy_reg[k-1] - xs;
                a_next = ca_reg[k-1] + atan_step(SHIFT);
            end
            else
            begin
                x_next = cx_reg[k-1] - ys;
                y_next = cy_reg[k-1] + xs;
                a_next = ca_reg[k-1] - atan_step(SHIFT);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[k] <= 1'b0;
            else if (en)
                cv_reg[k] <= cv_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[k] <= x_next;
                cy_reg[k] <= y_next;
                ca_reg[k] <= a_next;
                cs_reg[k] <= cs_reg[k-1];
            end
        end
    end

    // clamp the angle to [0, half turn]
    logic                    ang_valid_reg;
    logic [ANGU_W-1:0]       ang_reg;
    cside_t                  ang_side_reg;
    logic [ANGU_W-1:0]       ang_next;
    logic signed [ANG_W-1:0] a_end;

    assign a_end = ca_reg[CORDIC_STEPS];

    always_comb
    begin
        if (a_end < 0)
            ang_next = '0;
        else if (a_end > $signed({1'b0, ANG_MAX}))
            ang_next = ANG_MAX;
        else
            ang_next = a_end[ANGU_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ang_valid_reg <= 1'b0;
        else if (en)
            ang_valid_reg <= cv_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg      <= ang_next;
            ang_side_reg <= cs_reg[CORDIC_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // axis * angle: |d|*2^14*ang*2 over len*512, rounded
    // ------------------------------------------------------------------
    flags_t                  div_flags_in;
    logic                    dq_valid;
    logic [2:0][QUOT_W-1:0]  dq;
    flags_t                  dq_flags;

    assign div_flags_in = '{neg:   ang_side_reg.info.neg,
                            axis:  ang_side_reg.info.axis,
                            degen: ang_side_reg.info.degen};

    rm2aa_div3 #(
        .TAG_W ($bits(flags_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ang_valid_reg),
        .in_ang    (ang_reg),
        .in_len    (ang_side_reg.len),
        .in_mag    (ang_side_reg.info.mag),
        .in_tag    (div_flags_in),
        .out_valid (dq_valid),
        .out_quot  (dq),
        .out_tag   (dq_flags)
    );

    // ------------------------------------------------------------------
    // output register: restore signs, zero the degenerate case
    // ------------------------------------------------------------------
    logic signed [ROT_W-1:0] out_rot_reg [3];
    axis_t                   out_axis_reg;
    logic                    out_degen_reg;
    logic signed [ROT_W-1:0] rot_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dq_flags.degen)
                rot_next[i] = '0;
            else if (dq_flags.neg[i])
                rot_next[i] = -$signed(dq[i]);
            else
                rot_next[i] = $signed(dq[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                out_rot_reg[i] <= rot_next[i];
            out_axis_reg  <= dq_flags.axis;
            out_degen_reg <= dq_flags.degen;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-3*ROT_W){1'b0}}, out_rot_reg[2], out_rot_reg[1],
                            out_rot_reg[0]};
    assign m_axis_tuser  = {out_degen_reg, out_axis_reg};

`ifndef NO_ASSERTIONS
    // a degenerate item carries a zero rotation and the z axis
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            (m_axis_tdata[3*ROT_W-1:0] == '0) && (m_axis_tuser[1:0] == AXIS_Z))
        else $error("degenerate item with nonzero rotation");

    // the rounded quotient never leaves the half turn range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (out_rot_reg[0] <= ROT_LIM) && (out_rot_reg[0] >= -ROT_LIM) &&
            (out_rot_reg[1] <= ROT_LIM) && (out_rot_reg[1] >= -ROT_LIM) &&
            (out_rot_reg[2] <= ROT_LIM) && (out_rot_reg[2] >= -ROT_LIM))
        else $error("rotation component out of range");

    // both square root pipelines carry the same items
    assert property (@(posedge clk) disable iff (!rst_n)
        sa_valid |-> sb_valid)
        else $error("square root pipelines out of step");
`endif

endmodule
